>>> hdl/sll_pkg.sv
// Shared types, constants and helpers for the static linked list engine.
package sll_pkg;

    localparam int SLOTS      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int LINK_W     = $clog2(SLOTS);
    localparam int POS_W      = 7;
    localparam int CNT_W      = 6;

    localparam logic [LINK_W-1:0] HEAD_FREE = '0;
    localparam logic [LINK_W-1:0] HEAD_LIST = LINK_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]                    op;
        logic [POS_W-1:0]              position;
        logic signed [DATA_WIDTH-1:0]  value;
    } t_req;

    typedef struct packed {
        logic [1:0]                    status;
        logic signed [DATA_WIDTH-1:0]  read_value;
        logic [CNT_W-1:0]              count;
    } t_rsp;

    typedef struct packed {
        logic              wr_en;
        logic [LINK_W-1:0] wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic [LINK_W-1:0] rd_addr;
    } t_link_req;

    typedef struct packed {
        logic valid;
        t_rsp rsp;
    } t_seq_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FREE,
        S_POP,
        S_WALK,
        S_HOP,
        S_SUCC,
        S_INS_LINK,
        S_DEL_UNLINK,
        S_DEL_PUSH,
        S_DEL_HEAD,
        S_RD_VALUE,
        S_DONE
    } t_state;

    // Link held by an entry that has not been written since reset.
    function automatic logic [LINK_W-1:0] reset_link(input logic [LINK_W-1:0] addr);
        logic [LINK_W:0] nxt;
        nxt = {1'b0, addr} + (LINK_W+1)'(1);
        if (addr < LINK_W'(SLOTS - 2)) begin
            return nxt[LINK_W-1:0];
        end
        return '0;
    endfunction

endpackage

>>> hdl/static_linked_list_engine_unit.sv
// Top level of the static linked list engine: sequencer, link memory, output register.
//
// Array-backed linked list of up to 62 signed 32-bit elements with a free chain.
// Request channel (i_valid/o_ready, i_req): op insert, delete or read at a
// one-based position; value is stored on insert. Response channel
// (o_valid/i_ready, o_rsp): status, read_value and the element count after
// the operation. One response per request, in order.
// One request is in flight at a time; o_ready is high only while idle.
// Latency from request to response is set by the list walk; each hop reads
// the next link through the registered link memory read port (S_WALK, S_HOP).
// A bad position, or an insert that finds no free node, ends the request
// without a walk. Insert and delete at position 62 take longest.
// Reset gives an empty list with all 62 nodes on the free chain; it takes
// effect through per-entry valid bits on the link memory.
// A stalled response sits in the output register; the engine finishes the
// next operation only once that register can be loaded.
module static_linked_list_engine_unit
    import sll_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    t_link_req         link_req;
    logic [LINK_W-1:0] link_data;
    t_seq_out          seq_res;
    logic              take;

    logic r_out_valid;
    t_rsp r_out;

    assign take = seq_res.valid && (!r_out_valid || i_ready);

    sll_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .i_take     (take),
        .o_res      (seq_res),
        .o_link     (link_req),
        .i_link_data(link_data)
    );

    sll_link_mem u_link_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (link_req),
        .o_rd_data(link_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= seq_res.rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

>>> hdl/sll_link_mem.sv
// Link memory with per-entry valid bits that stand in for the reset free chain.
module sll_link_mem
    import sll_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_link_req         i_req,
    output logic [LINK_W-1:0] o_rd_data
);

    logic [LINK_W-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0]  r_valid;
    logic [LINK_W-1:0] r_rd_data;
    logic [LINK_W-1:0] r_rd_addr;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data  <= r_mem[i_req.rd_addr];
        r_rd_addr  <= i_req.rd_addr;
        r_rd_valid <= r_valid[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : reset_link(r_rd_addr);

endmodule

>>> hdl/sll_seq.sv
// Sequencer: position check, list walk with a shared hop counter, splices, value store.
module sll_seq
    import sll_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_req              i_req,
    input  logic              i_take,
    output t_seq_out          o_res,
    output t_link_req         o_link,
    input  logic [LINK_W-1:0] i_link_data
);

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [LINK_W-1:0] r_node, n_node;
    logic [LINK_W-1:0] r_fresh, n_fresh;
    logic [POS_W-1:0]  r_hop, n_hop;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [1:0]        r_status, n_status;
    logic signed [DATA_WIDTH-1:0] r_rdval, n_rdval;

    logic signed [DATA_WIDTH-1:0] r_vmem [SLOTS];
    logic signed [DATA_WIDTH-1:0] r_vdata;
    logic              v_we;
    logic [LINK_W-1:0] v_raddr;

    logic [POS_W-1:0] cnt_ext;
    logic [POS_W-1:0] cnt_p1;
    logic             pos_bad;

    assign cnt_ext = POS_W'(r_count);
    assign cnt_p1  = cnt_ext + POS_W'(1);

    always_comb begin
        case (r_req.op)
            OP_INSERT: pos_bad = (r_req.position == '0) || (r_req.position > cnt_p1);
            OP_DELETE,
            OP_READ:   pos_bad = (r_req.position == '0) || (r_req.position > cnt_ext);
            default:   pos_bad = 1'b1;
        endcase
    end

    // next state and register updates
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_node   = r_node;
        n_fresh  = r_fresh;
        n_hop    = r_hop;
        n_count  = r_count;
        n_status = r_status;
        n_rdval  = r_rdval;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req    = i_req;
                    n_status = ST_BADPOS;
                    n_rdval  = '0;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_node = HEAD_LIST;
                n_hop  = POS_W'(1);
                if (pos_bad) begin
                    n_state = S_DONE;
                end else if (r_req.op == OP_INSERT) begin
                    n_state = S_FREE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_FREE: begin
                n_fresh = i_link_data;
                if (i_link_data == HEAD_FREE) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: n_state = S_WALK;
            S_WALK: begin
                if (r_hop < r_req.position) begin
                    n_state = S_HOP;
                end else begin
                    n_state = S_SUCC;
                end
            end
            S_HOP: begin
                n_node  = i_link_data;
                n_hop   = r_hop + POS_W'(1);
                n_state = S_WALK;
            end
            S_SUCC: begin
                case (r_req.op)
                    OP_INSERT: n_state = S_INS_LINK;
                    OP_DELETE: begin
                        n_fresh = i_link_data;
                        n_state = S_DEL_UNLINK;
                    end
                    default:   n_state = S_RD_VALUE;
                endcase
            end
            S_INS_LINK: begin
                n_count  = r_count + CNT_W'(1);
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_DEL_UNLINK: n_state = S_DEL_PUSH;
            S_DEL_PUSH:   n_state = S_DEL_HEAD;
            S_DEL_HEAD: begin
                n_count  = r_count - CNT_W'(1);
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_RD_VALUE: begin
                n_rdval  = r_vdata;
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory requests and handshake
    always_comb begin
        o_link  = '0;
        v_we    = 1'b0;
        v_raddr = i_link_data;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE:  o_ready = 1'b1;
            S_CHECK: o_link.rd_addr = HEAD_FREE;
            S_FREE:  o_link.rd_addr = i_link_data;
            S_POP: begin
                o_link.wr_en   = 1'b1;
                o_link.wr_addr = HEAD_FREE;
                o_link.wr_data = i_link_data;
                v_we           = 1'b1;
            end
            S_WALK:  o_link.rd_addr = r_node;
            S_SUCC: begin
                if (r_req.op == OP_INSERT) begin
                    o_link.wr_en   = 1'b1;
                    o_link.wr_addr = r_fresh;
                    o_link.wr_data = i_link_data;
                end
                o_link.rd_addr = i_link_data;
            end
            S_INS_LINK: begin
                o_link.wr_en   = 1'b1;
                o_link.wr_addr = r_node;
                o_link.wr_data = r_fresh;
            end
            S_DEL_UNLINK: begin
                o_link.wr_en   = 1'b1;
                o_link.wr_addr = r_node;
                o_link.wr_data = i_link_data;
                o_link.rd_addr = HEAD_FREE;
            end
            S_DEL_PUSH: begin
                o_link.wr_en   = 1'b1;
                o_link.wr_addr = r_fresh;
                o_link.wr_data = i_link_data;
            end
            S_DEL_HEAD: begin
                o_link.wr_en   = 1'b1;
                o_link.wr_addr = HEAD_FREE;
                o_link.wr_data = r_fresh;
            end
            default: o_link = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_node   <= n_node;
        r_fresh  <= n_fresh;
        r_hop    <= n_hop;
        r_status <= n_status;
        r_rdval  <= n_rdval;
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vmem[r_fresh] <= r_req.value;
        end
        r_vdata <= r_vmem[v_raddr];
    end

    assign o_res.valid          = (r_state == S_DONE);
    assign o_res.rsp.status     = r_status;
    assign o_res.rsp.read_value = r_rdval;
    assign o_res.rsp.count      = r_count;

endmodule

>>> hdl/sll_checker.sv
// Port-level checks for the static linked list engine, bound to the top level.
module sll_checker
    import sll_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input t_req i_req,
    input logic o_valid,
    input logic i_ready,
    input t_rsp o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rsp)))
        else $error("stalled response changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.status == ST_OK || o_rsp.read_value == '0))
        else $error("failed request returned data");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.count <= CNT_W'(SLOTS - 2)))
        else $error("count beyond node capacity");

endmodule

bind static_linked_list_engine_unit sll_checker u_sll_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_ready(o_ready),
    .i_req  (i_req),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_rsp  (o_rsp)
);
